// ===== design/orthonormal_basis_from_vector_top_assert.svh =====
// assertion macros for the orthonormal basis block
`ifndef ORTHONORMAL_BASIS_FROM_VECTOR_TOP_ASSERT_SVH
`define ORTHONORMAL_BASIS_FROM_VECTOR_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define OBFV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define OBFV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/obfv_pkg.sv =====
// shared constants and types for the orthonormal basis block
`default_nettype none
package obfv_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int UW         = FRAC_BITS + 2;
  localparam int ROOT_STEPS = 32;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  typedef struct packed {
    logic        first;
    logic        neg_a;
    logic        neg_b;
    logic        degen;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } item_t;

  typedef struct packed {
    logic valid;
    logic almost_full;
  } qstat_t;
endpackage
`default_nettype wire

// ===== design/obfv_front.sv =====
// front end: picks the form, takes magnitudes and normalizes them
`default_nettype none
module obfv_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic [31:0]    in_x,
  input  wire logic [31:0]    in_y,
  input  wire logic [31:0]    in_z,
  output logic                push,
  output obfv_pkg::item_t     push_item
);
  import obfv_pkg::*;

  function automatic logic [5:0] lzc(input logic [31:0] v);
    logic [5:0] cnt;
    cnt = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) cnt = 6'(31 - i);
    end
    lzc = cnt;
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

  logic        a_v_r;
  item_t       a_it_r;
  item_t       a_it_nxt;
  logic [31:0] ax, ay, az;
  logic [31:0] mx;
  logic [5:0]  lz;
  logic [4:0]  sh;
  item_t       b_it_nxt;

  always_comb begin
    ax = mag(in_x);
    ay = mag(in_y);
    az = mag(in_z);
    a_it_nxt.first = ax > ay;
    a_it_nxt.ma    = az;
    a_it_nxt.mb    = a_it_nxt.first ? ax : ay;
    a_it_nxt.neg_a = a_it_nxt.first ? in_z[31] : (in_z != 32'd0 && !in_z[31]);
    a_it_nxt.neg_b = a_it_nxt.first ? (in_x != 32'd0 && !in_x[31]) : in_y[31];
    a_it_nxt.degen = (az == 32'd0) && (a_it_nxt.mb == 32'd0);
    a_it_nxt.vx    = in_x;
    a_it_nxt.vy    = in_y;
    a_it_nxt.vz    = in_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    a_it_r <= a_it_nxt;
  end

  // shift the larger magnitude up into [2^30, 2^31]
  always_comb begin
    mx = (a_it_r.ma > a_it_r.mb) ? a_it_r.ma : a_it_r.mb;
    lz = lzc(mx);
    sh = (lz <= 6'd1) ? 5'd0 : 5'(lz - 6'd1);
    b_it_nxt    = a_it_r;
    b_it_nxt.ma = a_it_r.ma << sh;
    b_it_nxt.mb = a_it_r.mb << sh;
  end

  logic  b_v_r;
  item_t b_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_it_r <= b_it_nxt;
  end

  assign push      = b_v_r;
  assign push_item = b_it_r;
endmodule
`default_nettype wire

// ===== design/obfv_queue.sv =====
// short queue between front and back end
`default_nettype none
module obfv_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  obfv_pkg::item_t     push_item,
  input  wire logic           pop,
  output obfv_pkg::qstat_t    stat,
  output obfv_pkg::item_t     head
);
  import obfv_pkg::*;

  item_t        mem [0:QDEPTH-1];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_item;
  end

  assign head             = mem[rp_r];
  assign stat.valid       = (cnt_r != '0);
  assign stat.almost_full = (cnt_r >= (QAW + 1)'(QDEPTH - 2));
endmodule
`default_nettype wire

// ===== design/obfv_back.sv =====
// back end: root, divides and cross product
`default_nettype none
module obfv_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  obfv_pkg::qstat_t    stat,
  input  obfv_pkg::item_t     head,
  output logic                pop,
  output logic                out_valid,
  output logic [31:0]         out_basis_u_x,
  output logic [31:0]         out_basis_u_y,
  output logic [31:0]         out_basis_u_z,
  output logic [31:0]         out_basis_w_x,
  output logic [31:0]         out_basis_w_y,
  output logic [31:0]         out_basis_w_z,
  output logic                out_degenerate,
  output logic                out_saturated
);
  import obfv_pkg::*;

  localparam int DSTEPS = FRAC_BITS + 1;

  // round to nearest, ties up, then clamp; msb flags the clamp
  function automatic logic [32:0] rnd_clamp(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [63:0] q;
    t = p + (64'sd1 <<< (FRAC_BITS - 1));
    q = t >>> FRAC_BITS;
    if (q > 64'sd2147483647) rnd_clamp = {1'b1, 32'h7fffffff};
    else if (q < -64'sd2147483648) rnd_clamp = {1'b1, 32'h80000000};
    else rnd_clamp = {1'b0, q[31:0]};
  endfunction

  assign pop = stat.valid;

  // squares
  logic        s0_v_r;
  item_t       s0_it_r;
  logic [63:0] sqa_r, sqb_r, sqa_nxt, sqb_nxt;

  assign sqa_nxt = head.ma * head.ma;
  assign sqb_nxt = head.mb * head.mb;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else s0_v_r <= stat.valid;
  end

  always_ff @(posedge clk) begin
    s0_it_r <= head;
    sqa_r   <= sqa_nxt;
    sqb_r   <= sqb_nxt;
  end

  // integer square root, one result bit per stage
  logic        rt_v_r  [0:ROOT_STEPS];
  item_t       rt_it_r [0:ROOT_STEPS];
  logic [63:0] rt_s_r  [0:ROOT_STEPS];
  logic [63:0] rt_q_r  [0:ROOT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) rt_v_r[0] <= 1'b0;
    else rt_v_r[0] <= s0_v_r;
  end

  always_ff @(posedge clk) begin
    rt_it_r[0] <= s0_it_r;
    rt_s_r[0]  <= sqa_r + sqb_r;
    rt_q_r[0]  <= '0;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = rt_q_r[k] + RBIT;
    assign ge    = rt_s_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) rt_v_r[k+1] <= 1'b0;
      else rt_v_r[k+1] <= rt_v_r[k];
    end
    always_ff @(posedge clk) begin
      rt_it_r[k+1] <= rt_it_r[k];
      rt_s_r[k+1]  <= ge ? (rt_s_r[k] - trial) : rt_s_r[k];
      rt_q_r[k+1]  <= ge ? ((rt_q_r[k] >> 1) + RBIT) : (rt_q_r[k] >> 1);
    end
  end

  // two restoring dividers, one quotient bit per stage
  logic             dv_v_r  [0:DSTEPS];
  item_t            dv_it_r [0:DSTEPS];
  logic [31:0]      dv_r_r  [0:DSTEPS];
  logic [63:0]      dv_ra_r [0:DSTEPS];
  logic [63:0]      dv_rb_r [0:DSTEPS];
  logic [FRAC_BITS:0] dv_qa_r [0:DSTEPS];
  logic [FRAC_BITS:0] dv_qb_r [0:DSTEPS];
  logic [31:0]      root;

  assign root = rt_q_r[ROOT_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else dv_v_r[0] <= rt_v_r[ROOT_STEPS];
  end

  always_ff @(posedge clk) begin
    dv_it_r[0] <= rt_it_r[ROOT_STEPS];
    dv_r_r[0]  <= root;
    dv_ra_r[0] <= (64'(rt_it_r[ROOT_STEPS].ma) << FRAC_BITS) + 64'(root >> 1);
    dv_rb_r[0] <= (64'(rt_it_r[ROOT_STEPS].mb) << FRAC_BITS) + 64'(root >> 1);
    dv_qa_r[0] <= '0;
    dv_qb_r[0] <= '0;
  end

  for (genvar k = 0; k < DSTEPS; k++) begin : g_div
    localparam int J = FRAC_BITS - k;
    logic [63:0]        dsub;
    logic               gea, geb;
    logic [FRAC_BITS:0] qa_nxt, qb_nxt;
    always_comb begin
      dsub      = {32'd0, dv_r_r[k]} << J;
      gea       = dv_ra_r[k] >= dsub;
      geb       = dv_rb_r[k] >= dsub;
      qa_nxt    = dv_qa_r[k];
      qb_nxt    = dv_qb_r[k];
      qa_nxt[J] = gea;
      qb_nxt[J] = geb;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else dv_v_r[k+1] <= dv_v_r[k];
    end
    always_ff @(posedge clk) begin
      dv_it_r[k+1] <= dv_it_r[k];
      dv_r_r[k+1]  <= dv_r_r[k];
      dv_ra_r[k+1] <= gea ? (dv_ra_r[k] - dsub) : dv_ra_r[k];
      dv_rb_r[k+1] <= geb ? (dv_rb_r[k] - dsub) : dv_rb_r[k];
      dv_qa_r[k+1] <= qa_nxt;
      dv_qb_r[k+1] <= qb_nxt;
    end
  end

  // signed unit vector and the six products
  item_t                 dit;
  logic signed [UW-1:0]  ca, cb, ux, uy, uz;
  logic signed [63:0]    p_yz_nxt, p_zy_nxt, p_zx_nxt, p_xz_nxt, p_xy_nxt, p_yx_nxt;

  always_comb begin
    dit = dv_it_r[DSTEPS];
    ca  = $signed({1'b0, dv_qa_r[DSTEPS]});
    cb  = $signed({1'b0, dv_qb_r[DSTEPS]});
    if (dit.neg_a) ca = -ca;
    if (dit.neg_b) cb = -cb;
    ux  = dit.first ? ca : '0;
    uy  = dit.first ? '0 : ca;
    uz  = cb;
    p_yz_nxt = $signed(dit.vy) * uz;
    p_zy_nxt = $signed(dit.vz) * uy;
    p_zx_nxt = $signed(dit.vz) * ux;
    p_xz_nxt = $signed(dit.vx) * uz;
    p_xy_nxt = $signed(dit.vx) * uy;
    p_yx_nxt = $signed(dit.vy) * ux;
  end

  logic                 pm_v_r;
  logic                 pm_degen_r;
  logic signed [UW-1:0] pm_ux_r, pm_uy_r, pm_uz_r;
  logic signed [63:0]   p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pm_v_r <= 1'b0;
    else pm_v_r <= dv_v_r[DSTEPS];
  end

  always_ff @(posedge clk) begin
    pm_degen_r <= dit.degen;
    pm_ux_r    <= ux;
    pm_uy_r    <= uy;
    pm_uz_r    <= uz;
    p_yz_r     <= p_yz_nxt;
    p_zy_r     <= p_zy_nxt;
    p_zx_r     <= p_zx_nxt;
    p_xz_r     <= p_xz_nxt;
    p_xy_r     <= p_xy_nxt;
    p_yx_r     <= p_yx_nxt;
  end

  // rounding, clamping and the zero-divisor case
  logic [32:0] wx, wy, wz;

  assign wx = rnd_clamp(p_yz_r - p_zy_r);
  assign wy = rnd_clamp(p_zx_r - p_xz_r);
  assign wz = rnd_clamp(p_xy_r - p_yx_r);

  logic        o_v_r, o_dg_r, o_st_r;
  logic [31:0] o_ux_r, o_uy_r, o_uz_r, o_wx_r, o_wy_r, o_wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else o_v_r <= pm_v_r;
  end

  always_ff @(posedge clk) begin
    if (pm_degen_r) begin
      o_ux_r <= '0;
      o_uy_r <= '0;
      o_uz_r <= '0;
      o_wx_r <= '0;
      o_wy_r <= '0;
      o_wz_r <= '0;
      o_st_r <= 1'b0;
    end else begin
      o_ux_r <= 32'(pm_ux_r);
      o_uy_r <= 32'(pm_uy_r);
      o_uz_r <= 32'(pm_uz_r);
      o_wx_r <= wx[31:0];
      o_wy_r <= wy[31:0];
      o_wz_r <= wz[31:0];
      o_st_r <= wx[32] | wy[32] | wz[32];
    end
    o_dg_r <= pm_degen_r;
  end

  assign out_valid      = o_v_r;
  assign out_basis_u_x  = o_ux_r;
  assign out_basis_u_y  = o_uy_r;
  assign out_basis_u_z  = o_uz_r;
  assign out_basis_w_x  = o_wx_r;
  assign out_basis_w_y  = o_wy_r;
  assign out_basis_w_z  = o_wz_r;
  assign out_degenerate = o_dg_r;
  assign out_saturated  = o_st_r;
endmodule
`default_nettype wire

// ===== design/orthonormal_basis_from_vector_top.sv =====
// top level of the orthonormal basis block
//
//   channel   direction  transaction marked by       payload
//   input     in         start high, busy low        in_x, in_y, in_z
//   result    out        out_valid high, one cycle   out_basis_u_*, out_basis_w_*,
//                                                    out_degenerate, out_saturated
//
// one vector per cycle while busy is low, fully pipelined; a result passes the
// front end registers, the queue, the squares, the square root stages, the two
// dividers that run side by side, the products and the output register
// reset is synchronous, active low; it clears all valid bits and the queue
// the receiver cannot stall, so the back end never stops and busy stays low
// in practice; it only rises if the queue ever nears full
`default_nettype none
module orthonormal_basis_from_vector_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_x,
  input  wire logic [31:0] in_y,
  input  wire logic [31:0] in_z,
  output logic             out_valid,
  output logic [31:0]      out_basis_u_x,
  output logic [31:0]      out_basis_u_y,
  output logic [31:0]      out_basis_u_z,
  output logic [31:0]      out_basis_w_x,
  output logic [31:0]      out_basis_w_y,
  output logic [31:0]      out_basis_w_z,
  output logic             out_degenerate,
  output logic             out_saturated
);
  import obfv_pkg::*;

  logic   acc;
  logic   push, pop;
  item_t  push_item, head;
  qstat_t stat;
  logic   degen_clean;
  logic   u_has_zero;

  // a transaction is taken whenever start meets a free queue
  assign acc  = start && !busy;
  assign busy = stat.almost_full;

  // classify and normalize
  obfv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  obfv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .stat      (stat),
    .head      (head)
  );

  // root, divides, cross product
  obfv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .stat           (stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_basis_u_x  (out_basis_u_x),
    .out_basis_u_y  (out_basis_u_y),
    .out_basis_u_z  (out_basis_u_z),
    .out_basis_w_x  (out_basis_w_x),
    .out_basis_w_y  (out_basis_w_y),
    .out_basis_w_z  (out_basis_w_z),
    .out_degenerate (out_degenerate),
    .out_saturated  (out_saturated)
  );

  assign degen_clean = !out_saturated && out_basis_u_x == 32'd0 &&
                       out_basis_u_y == 32'd0 && out_basis_u_z == 32'd0 &&
                       out_basis_w_x == 32'd0;
  assign u_has_zero  = out_basis_u_x == 32'd0 || out_basis_u_y == 32'd0;

  `include "orthonormal_basis_from_vector_top_assert.svh"

  // a degenerate result is zero in all of u and in w_x, and never saturated
  `OBFV_ASSERT_SAME(a_degen_zero, out_valid && out_degenerate, degen_clean, "degenerate not zero")
  // the unit vector always has a structural zero in x or y
  `OBFV_ASSERT_SAME(a_u_zero, out_valid, u_has_zero, "unit vector has no zero component")
  // the back end drains every cycle, so the queue never backs up
  `OBFV_ASSERT_NEXT(a_no_busy, 1'b1, !busy, "queue backed up")
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the orthonormal basis block: directed table plus random vectors
`timescale 1ns / 1ps
module tb_top;
  import obfv_pkg::*;

  // result fields in one record, same order as the output ports
  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
    logic        degen;
    logic        sat;
  } basis_t;

  // one row of the directed table; has_exp marks a typed-in expectation
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          has_exp;
    basis_t      exp;
  } vec_row_t;

  localparam int      NUM_RANDOM = 600;
  localparam int      DRAIN_CYCLES = FRAC_BITS + 60;
  localparam logic [31:0] ONE = 32'h1 << FRAC_BITS;
  localparam logic [31:0] NEG_ONE = -(32'sh1 <<< FRAC_BITS);
  localparam logic [31:0] MAXP = 32'h7fffffff;
  localparam logic [31:0] MINN = 32'h80000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_x, in_y, in_z;
  logic        out_valid;
  logic [31:0] out_basis_u_x, out_basis_u_y, out_basis_u_z;
  logic [31:0] out_basis_w_x, out_basis_w_y, out_basis_w_z;
  logic        out_degenerate, out_saturated;

  basis_t      expected_basis_q[$];
  int          error_count;
  int          sent_count;
  int          got_count;
  int          degen_seen;
  int          sat_seen;

  orthonormal_basis_from_vector_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .out_valid      (out_valid),
    .out_basis_u_x  (out_basis_u_x),
    .out_basis_u_y  (out_basis_u_y),
    .out_basis_u_z  (out_basis_u_z),
    .out_basis_w_x  (out_basis_w_x),
    .out_basis_w_y  (out_basis_w_y),
    .out_basis_w_z  (out_basis_w_z),
    .out_degenerate (out_degenerate),
    .out_saturated  (out_saturated)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor square root of a 64-bit value, bit by bit
  function automatic logic [63:0] isqrt(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // rounded divide of a shifted magnitude by the root, sign applied
  function automatic longint unit_component(logic [63:0] m, bit neg, logic [63:0] r);
    logic [63:0] q;
    q = ((m << FRAC_BITS) + (r >> 1)) / r;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // drop the fraction with ties toward plus infinity, clamp to 32 bits
  function automatic logic [31:0] cross_round(longint t, ref bit sat);
    longint q;
    t = t + (longint'(1) <<< (FRAC_BITS - 1));
    q = t >>> FRAC_BITS;
    if (q > longint'(32'sh7fffffff)) begin
      sat = 1;
      return MAXP;
    end
    if (q < -longint'(64'h80000000)) begin
      sat = 1;
      return MINN;
    end
    return q[31:0];
  endfunction

  // predicted basis for one input vector
  function automatic basis_t predict_basis(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    basis_t      b;
    longint      vx, vy, vz, pa, pb, ux, uy, uz, ca, cb;
    logic [63:0] ma, mb, mx, r;
    bit          first, sat;
    vx = longint'(signed'(x));
    vy = longint'(signed'(y));
    vz = longint'(signed'(z));
    ux = 0; uy = 0; uz = 0;
    sat = 0;
    b = '0;
    first = (vx < 0 ? -vx : vx) > (vy < 0 ? -vy : vy);
    pa = first ? vz : -vz;
    pb = first ? -vx : vy;
    ma = pa < 0 ? -pa : pa;
    mb = pb < 0 ? -pb : pb;
    if (ma == 0 && mb == 0) begin
      b.degen = 1'b1;
      return b;
    end
    mx = ma > mb ? ma : mb;
    while (mx < (64'h1 << 30)) begin
      ma = ma << 1;
      mb = mb << 1;
      mx = mx << 1;
    end
    r = isqrt(ma * ma + mb * mb);
    ca = unit_component(ma, pa < 0, r);
    cb = unit_component(mb, pb < 0, r);
    if (first) begin
      ux = ca;
      uz = cb;
    end else begin
      uy = ca;
      uz = cb;
    end
    b.ux = ux[31:0];
    b.uy = uy[31:0];
    b.uz = uz[31:0];
    b.wx = cross_round(vy * uz - vz * uy, sat);
    b.wy = cross_round(vz * ux - vx * uz, sat);
    b.wz = cross_round(vx * uy - vy * ux, sat);
    b.sat = sat;
    return b;
  endfunction

  // one line per mismatch, counted
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // known vectors with expectations typed in where they are obvious
  function automatic vec_row_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   bit has, basis_t e);
    vec_row_t row;
    row.x = x; row.y = y; row.z = z; row.has_exp = has; row.exp = e;
    return row;
  endfunction

  vec_row_t vec_table[$];

  // draw one random component, weighted toward edge values
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return MAXP;
      2: return MINN;
      3: return $urandom_range(0, 3) == 0 ? ONE : NEG_ONE;
      4: return 32'(signed'($urandom_range(0, 511)) - 256);
      5: return 32'($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // send one vector, after a random gap with start low
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             bit has, basis_t e, int gap);
    basis_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = predict_basis(x, y, z);
    if (has && pred != e)
      $display("note: table row %h %h %h disagrees with predictor", x, y, z);
    start <= 1'b1;
    in_x  <= x;
    in_y  <= y;
    in_z  <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    // the edge just passed accepted the vector
    expected_basis_q.push_back(has ? e : pred);
    sent_count++;
  endtask

  // result side: sample on the edge, compare with the oldest expectation
  always @(posedge clk) begin
    basis_t e;
    if (rst_n && out_valid) begin
      got_count++;
      if (expected_basis_q.size() == 0) begin
        error_count++;
        $display("%0t result with no transaction waiting", $realtime);
      end else begin
        e = expected_basis_q.pop_front();
        if (out_basis_u_x !== e.ux) report_mismatch("u_x", out_basis_u_x, e.ux);
        if (out_basis_u_y !== e.uy) report_mismatch("u_y", out_basis_u_y, e.uy);
        if (out_basis_u_z !== e.uz) report_mismatch("u_z", out_basis_u_z, e.uz);
        if (out_basis_w_x !== e.wx) report_mismatch("w_x", out_basis_w_x, e.wx);
        if (out_basis_w_y !== e.wy) report_mismatch("w_y", out_basis_w_y, e.wy);
        if (out_basis_w_z !== e.wz) report_mismatch("w_z", out_basis_w_z, e.wz);
        if (out_degenerate !== e.degen)
          report_mismatch("degenerate", 32'(out_degenerate), 32'(e.degen));
        if (out_saturated !== e.sat)
          report_mismatch("saturated", 32'(out_saturated), 32'(e.sat));
        if (e.degen) degen_seen++;
        if (e.sat) sat_seen++;
      end
    end
  end

  // main sequence
  initial begin
    basis_t zero_b, degen_b, e;
    int     gap, burst, drain;
    error_count = 0; sent_count = 0; got_count = 0; degen_seen = 0; sat_seen = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_x = '0; in_y = '0; in_z = '0;
    zero_b = '0;
    degen_b = '0;
    degen_b.degen = 1'b1;

    // zero vector and vectors along z with x = y = 0 pick the second form;
    // the zero divisor case gives zeros and the degenerate flag
    vec_table.push_back(mk(0, 0, 0, 1, degen_b));
    // unit x: first form, u = (0,0,-1), w = x cross u = (0,1,0)
    e = '0; e.uz = NEG_ONE; e.wy = ONE;
    vec_table.push_back(mk(ONE, 0, 0, 1, e));
    // unit y: second form, u = (0,0,1), w = (1,0,0)
    e = '0; e.uz = ONE; e.wx = ONE;
    vec_table.push_back(mk(0, ONE, 0, 1, e));
    // unit z: second form with b = 0, u = (0,-1,0), w = (1,0,0)
    e = '0; e.uy = NEG_ONE; e.wx = ONE;
    vec_table.push_back(mk(0, 0, ONE, 1, e));
    // equal magnitudes of x and y take the second form
    vec_table.push_back(mk(ONE, ONE, ONE, 0, zero_b));
    vec_table.push_back(mk(NEG_ONE, ONE, 0, 0, zero_b));
    // most negative and most positive components, saturating cross products
    vec_table.push_back(mk(MINN, 0, 0, 0, zero_b));
    vec_table.push_back(mk(0, MINN, MINN, 0, zero_b));
    vec_table.push_back(mk(MINN, MINN, MINN, 0, zero_b));
    vec_table.push_back(mk(MAXP, MAXP, MAXP, 0, zero_b));
    vec_table.push_back(mk(MAXP, MINN, MAXP, 0, zero_b));
    vec_table.push_back(mk(MINN, MAXP, MINN, 0, zero_b));
    vec_table.push_back(mk(MAXP, 0, MINN, 0, zero_b));
    // smallest magnitudes, where the normalizing shift is largest, then mixed bit patterns
    vec_table.push_back(mk(1, 0, 0, 0, zero_b));
    vec_table.push_back(mk(0, 32'hffffffff, 1, 0, zero_b));
    vec_table.push_back(mk(32'hffffffff, 0, 32'hffffffff, 0, zero_b));
    vec_table.push_back(mk(3, 2, 1, 0, zero_b));
    vec_table.push_back(mk(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 0, zero_b));
    vec_table.push_back(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, zero_b));
    vec_table.push_back(mk(32'h55555555, 32'haaaaaaaa, 32'h55555555, 0, zero_b));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (vec_table[i]) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      send_vector(vec_table[i].x, vec_table[i].y, vec_table[i].z,
                  vec_table[i].has_exp, vec_table[i].exp, gap);
    end

    // random vectors; bursts with no gap alternate with random gaps
    burst = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (burst == 0) burst = $urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : 0;
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 8);
      end
      send_vector(rand_comp(), rand_comp(), rand_comp(), 0, zero_b, gap);
    end
    start <= 1'b0;

    // wait for every expected result, then keep watching for stray results
    drain = 0;
    while (expected_basis_q.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_basis_q.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", expected_basis_q.size());
    end

    $display("sent %0d vectors, checked %0d results", sent_count, got_count);
    $display("degenerate results %0d, saturated results %0d", degen_seen, sat_seen);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/obfv_pkg.sv
design/obfv_front.sv
design/obfv_queue.sv
design/obfv_back.sv
design/orthonormal_basis_from_vector_top.sv
dv/tb_top.sv
